### rtl/rgcb_pkg.sv
// ----------------------------------------------------------------------------
// rgcb_pkg
// Shared types and constants of the glyph column blitter: request fields,
// opcodes, sequencer states and the cursor control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package rgcb_pkg;

	// field widths of one request and one result
	localparam int OP_W      = 2;
	localparam int SCOL_W    = 10;
	localparam int BASE_W    = 5;
	localparam int HEIGHT_W  = 6;
	localparam int GWIDTH_W  = 8;
	localparam int BYTE_W    = 8;
	localparam int IDX_W     = 8;
	localparam int WORD_W    = 32;
	localparam int ADV_W     = 8;

	// cursor arithmetic: column reaches up to 511, row up to 31 + 63
	localparam int COL_W     = 11;
	localparam int ROW_W     = 7;
	localparam int ROW_STEP  = 8;

	// run counter: a run header gives at most 127 repeats
	localparam int CNT_W     = 7;

	typedef enum logic [OP_W-1:0] {
		OP_START = 2'd0,
		OP_DATA  = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_PUT_RD,
		S_PUT_WR,
		S_READ,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t                         op;
		logic signed [SCOL_W-1:0]    start_col;
		logic [BASE_W-1:0]           base_line;
		logic [HEIGHT_W-1:0]         glyph_height;
		logic [GWIDTH_W-1:0]         glyph_width;
		logic                        compressed;
		logic [BYTE_W-1:0]           data_byte;
		logic [IDX_W-1:0]            column_index;
	} item_t;

	typedef struct packed {
		logic                        load;
		logic                        step;
		logic signed [SCOL_W-1:0]    start_col;
		logic [BASE_W-1:0]           base_line;
		logic [HEIGHT_W-1:0]         glyph_height;
	} cur_cmd_t;

	typedef struct packed {
		logic                        on_screen;
		logic signed [COL_W-1:0]     col;
		logic [ROW_W-1:0]            row;
	} cur_stat_t;

endpackage

`default_nettype wire

### rtl/rgcb_ram.sv
// ----------------------------------------------------------------------------
// rgcb_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rgcb_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 156,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [WIDTH-1:0]  wdata,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and read the addressed entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/rgcb_cursor.sv
// ----------------------------------------------------------------------------
// rgcb_cursor
// Glyph write cursor: holds the current column, row position, base line and
// height, and steps down one byte row at a time, wrapping to the next column.
// ----------------------------------------------------------------------------
`default_nettype none

module rgcb_cursor #(
	parameter int DISPLAY_COLUMNS = 156
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rgcb_pkg::cur_cmd_t   cmd,
	output rgcb_pkg::cur_stat_t       stat
);

	import rgcb_pkg::*;

	localparam logic signed [COL_W-1:0] LAST_COL = COL_W'(DISPLAY_COLUMNS);

	logic signed [COL_W-1:0] col_q;
	logic [ROW_W-1:0]        row_q;
	logic [BASE_W-1:0]       base_q;
	logic [HEIGHT_W-1:0]     height_q;

	logic signed [ROW_W:0]   row_dn;
	logic signed [ROW_W:0]   base_ext;
	logic                    wrap;
	logic [ROW_W-1:0]        row_top;
	logic [ROW_W-1:0]        load_top;

	// next row below, and the wrap test against the base line
	always_comb begin
		row_dn   = $signed({1'b0, row_q}) - $signed((ROW_W+1)'(ROW_STEP));
		base_ext = $signed((ROW_W+1)'(base_q));
		wrap     = (row_dn <= base_ext);
		row_top  = ROW_W'(base_q) + ROW_W'(height_q);
		load_top = ROW_W'(cmd.base_line) + ROW_W'(cmd.glyph_height);
	end

	// load on glyph start, advance on each placed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			base_q   <= '0;
			height_q <= '0;
		end else if (cmd.load) begin
			col_q    <= {{(COL_W-SCOL_W){cmd.start_col[SCOL_W-1]}}, cmd.start_col};
			row_q    <= load_top;
			base_q   <= cmd.base_line;
			height_q <= cmd.glyph_height;
		end else if (cmd.step) begin
			if (wrap) begin
				row_q <= row_top;
				if (col_q < LAST_COL) begin
					col_q <= col_q + COL_W'(1);
				end
			end else begin
				row_q <= row_dn[ROW_W-1:0];
			end
		end
	end

	// report position and whether the column lies on the display
	always_comb begin
		stat.on_screen = (col_q >= $signed(COL_W'(0))) && (col_q < LAST_COL);
		stat.col       = col_q;
		stat.row       = row_q;
	end

endmodule

`default_nettype wire

### rtl/rgcb_engine.sv
// ----------------------------------------------------------------------------
// rgcb_engine
// Request sequencer: clears the column store after reset, decodes glyph
// starts and run-length headers, and performs the read-modify-write of each
// placed byte as well as column reads and clears.
// ----------------------------------------------------------------------------
`default_nettype none

module rgcb_engine #(
	parameter int DISPLAY_COLUMNS = 156,
	parameter int COLUMN_BITS     = 32,
	parameter int ADDR_W          = (DISPLAY_COLUMNS > 1) ? $clog2(DISPLAY_COLUMNS) : 1
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// request side
	input  wire logic                       req_valid,
	output logic                            req_ready,
	input  wire rgcb_pkg::item_t            req_item,
	// result side
	input  wire logic                       res_free,
	output logic                            res_load,
	output logic [rgcb_pkg::WORD_W-1:0]     res_word,
	output logic [rgcb_pkg::ADV_W-1:0]      res_adv,
	// cursor
	output rgcb_pkg::cur_cmd_t              cur_cmd,
	input  wire rgcb_pkg::cur_stat_t        cur_stat,
	// column store
	output logic                            ram_we,
	output logic [ADDR_W-1:0]               ram_addr,
	output logic [COLUMN_BITS-1:0]          ram_wdata,
	input  wire logic [COLUMN_BITS-1:0]     ram_rdata
);

	import rgcb_pkg::*;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DISPLAY_COLUMNS - 1);
	localparam logic [COL_W-1:0]  NCOLS     = COL_W'(DISPLAY_COLUMNS);

	state_t            state_q, state_nxt;
	item_t             item_q;
	logic [ADDR_W-1:0] clr_q;
	logic              vis_q;
	logic              comp_q;
	logic              hdr_q;
	logic [CNT_W-1:0]  run_q;
	logic [7:0]        lit_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] word_q;
	logic [ADV_W-1:0]  adv_q;

	logic              idx_ok;
	logic              put_go;
	logic              last_put;
	logic              fin;
	logic [WORD_W-1:0] rd_word;
	logic [63:0]       rd_wide;
	logic [COLUMN_BITS-1:0] shifted;
	logic signed [COL_W-1:0] vis_sum;
	logic              vis_nxt;
	logic [7:0]        lit_dec;

	// request decode helpers
	always_comb begin
		idx_ok   = (COL_W'(item_q.column_index) < NCOLS);
		put_go   = vis_q && (!comp_q || !hdr_q);
		last_put = (cnt_q == CNT_W'(1));
		rd_wide  = 64'(ram_rdata);
		rd_word  = rd_wide[WORD_W-1:0];
		shifted  = COLUMN_BITS'(item_q.data_byte) << cur_stat.row;
		vis_sum  = {{(COL_W-SCOL_W){item_q.start_col[SCOL_W-1]}}, item_q.start_col}
			+ $signed(COL_W'(item_q.glyph_width));
		vis_nxt  = !vis_sum[COL_W-1] &&
			($signed({{(COL_W-SCOL_W){item_q.start_col[SCOL_W-1]}}, item_q.start_col})
			< $signed(NCOLS));
		lit_dec  = (lit_q != 8'd0) ? lit_q - 8'd1 : 8'd0;
	end

	// result of the current request is ready
	always_comb begin
		fin = 1'b0;
		unique case (state_q)
			S_EXEC: begin
				unique case (item_q.op)
					OP_START: fin = 1'b1;
					OP_DATA:  fin = !put_go;
					OP_READ:  fin = !idx_ok;
					OP_CLEAR: fin = 1'b1;
					default:  fin = 1'b1;
				endcase
			end
			S_PUT_RD: fin = !cur_stat.on_screen && last_put;
			S_PUT_WR: fin = last_put;
			S_READ:   fin = 1'b1;
			S_DONE:   fin = 1'b1;
			default:  fin = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == LAST_ADDR) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (fin) begin
					state_nxt = res_free ? S_IDLE : S_DONE;
				end else if (item_q.op == OP_READ) begin
					state_nxt = S_READ;
				end else begin
					state_nxt = S_PUT_RD;
				end
			end
			S_PUT_RD: begin
				if (fin) begin
					state_nxt = res_free ? S_IDLE : S_DONE;
				end else if (cur_stat.on_screen) begin
					state_nxt = S_PUT_WR;
				end
			end
			S_PUT_WR: begin
				if (fin) begin
					state_nxt = res_free ? S_IDLE : S_DONE;
				end else begin
					state_nxt = S_PUT_RD;
				end
			end
			S_READ, S_DONE: begin
				state_nxt = res_free ? S_IDLE : S_DONE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// outputs: handshake, store access, cursor commands, result
	always_comb begin
		req_ready         = (state_q == S_IDLE);
		ram_we            = 1'b0;
		ram_addr          = cur_stat.col[ADDR_W-1:0];
		ram_wdata         = '0;
		cur_cmd.load      = 1'b0;
		cur_cmd.step      = 1'b0;
		cur_cmd.start_col = item_q.start_col;
		cur_cmd.base_line = item_q.base_line;
		cur_cmd.glyph_height = item_q.glyph_height;
		res_load          = fin && res_free;
		res_word          = word_q;
		res_adv           = adv_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
			end
			S_EXEC: begin
				res_word = '0;
				res_adv  = (item_q.op == OP_START) ? item_q.glyph_width : '0;
				if (item_q.op == OP_READ || item_q.op == OP_CLEAR) begin
					ram_addr = ADDR_W'(item_q.column_index);
				end
				if (item_q.op == OP_CLEAR && idx_ok) begin
					ram_we = 1'b1;
				end
				if (item_q.op == OP_START) begin
					cur_cmd.load = 1'b1;
				end
			end
			S_PUT_RD: begin
				cur_cmd.step = !cur_stat.on_screen;
			end
			S_PUT_WR: begin
				ram_we       = 1'b1;
				ram_wdata    = ram_rdata | shifted;
				cur_cmd.step = 1'b1;
			end
			S_READ: begin
				res_word = rd_word;
			end
			S_IDLE, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			vis_q   <= 1'b0;
			comp_q  <= 1'b0;
			hdr_q   <= 1'b1;
			run_q   <= '0;
			lit_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			// sweep the store once after reset
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			// count down placed bytes
			if (cur_cmd.step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (state_q == S_EXEC) begin
				unique case (item_q.op)
					OP_START: begin
						vis_q  <= vis_nxt;
						comp_q <= item_q.compressed;
						hdr_q  <= 1'b1;
						run_q  <= '0;
						lit_q  <= '0;
					end
					OP_DATA: begin
						// a pending run repeats the byte, any other placed byte is placed once
						cnt_q <= (vis_q && comp_q && !hdr_q && run_q != '0) ?
							run_q : CNT_W'(1);
						if (vis_q && comp_q) begin
							priority if (hdr_q) begin
								// header: repeat count or literal count
								if (item_q.data_byte > 8'd128) begin
									run_q <= CNT_W'(8'd0 - item_q.data_byte);
									hdr_q <= 1'b0;
								end else if (item_q.data_byte != 8'd0) begin
									lit_q <= item_q.data_byte;
									hdr_q <= 1'b0;
								end
							end else if (run_q != '0) begin
								run_q <= '0;
								hdr_q <= 1'b1;
							end else begin
								lit_q <= lit_dec;
								if (lit_dec == 8'd0) begin
									hdr_q <= 1'b1;
								end
							end
						end
					end
					OP_READ, OP_CLEAR: begin
					end
					default: begin
					end
				endcase
			end
		end
	end

	// capture request and hold pending result
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_q <= req_item;
		end
		if (state_q == S_EXEC || state_q == S_READ) begin
			word_q <= res_word;
			adv_q  <= res_adv;
		end
	end

endmodule

`default_nettype wire

### rtl/rle_glyph_column_blitter.sv
// ----------------------------------------------------------------------------
// rle_glyph_column_blitter
// Decodes raw or run-length coded glyph bytes and ORs them into a column
// framebuffer held in a single-port RAM; columns can be read and cleared.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_axis; tuser carries the opcode (start glyph, data
//   byte, read column, clear column), tdata the other fields. Every request
//   gives exactly one result on m_axis: the column word for a read, the
//   glyph width for a start, zeros otherwise.
//   Requests are handled one at a time. A byte off the display only steps
//   the cursor; a run header followed by its data byte places up to 127
//   bytes.
//   Each placed byte costs a read and a write on the one RAM port.
//   After reset the block sweeps every column of the store, writing zeros,
//   with s_axis_tready low.
//   The result sits in an output register, so the next request is taken
//   while it waits; a further result holds inside until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_glyph_column_blitter #(
	parameter int DISPLAY_COLUMNS = 156,
	parameter int COLUMN_BITS     = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// start_col[9:0], base_line[14:10], glyph_height[20:15], glyph_width[28:21],
	// compressed[29], data_byte[37:30], column_index[45:38], zero[47:46]
	input  wire logic [47:0] s_axis_tdata,
	// opcode[1:0]
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// column_word[31:0], advance[39:32]
	output logic [39:0]      m_axis_tdata
);

	import rgcb_pkg::*;

	localparam int ADDR_W = (DISPLAY_COLUMNS > 1) ? $clog2(DISPLAY_COLUMNS) : 1;

	item_t                  item;
	cur_cmd_t               cur_cmd;
	cur_stat_t              cur_stat;
	logic                   res_free;
	logic                   res_load;
	logic [WORD_W-1:0]      res_word;
	logic [ADV_W-1:0]       res_adv;
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_addr;
	logic [COLUMN_BITS-1:0] ram_wdata;
	logic [COLUMN_BITS-1:0] ram_rdata;
	logic                   out_valid_q;
	logic [WORD_W-1:0]      out_word_q;
	logic [ADV_W-1:0]       out_adv_q;

	// unpack the request
	always_comb begin
		item.op           = op_t'(s_axis_tuser);
		item.start_col    = $signed(s_axis_tdata[9:0]);
		item.base_line    = s_axis_tdata[14:10];
		item.glyph_height = s_axis_tdata[20:15];
		item.glyph_width  = s_axis_tdata[28:21];
		item.compressed   = s_axis_tdata[29];
		item.data_byte    = s_axis_tdata[37:30];
		item.column_index = s_axis_tdata[45:38];
	end

	rgcb_engine #(
		.DISPLAY_COLUMNS (DISPLAY_COLUMNS),
		.COLUMN_BITS     (COLUMN_BITS),
		.ADDR_W          (ADDR_W)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req_item  (item),
		.res_free  (res_free),
		.res_load  (res_load),
		.res_word  (res_word),
		.res_adv   (res_adv),
		.cur_cmd   (cur_cmd),
		.cur_stat  (cur_stat),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata)
	);

	rgcb_cursor #(
		.DISPLAY_COLUMNS (DISPLAY_COLUMNS)
	) u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cur_cmd),
		.stat   (cur_stat)
	);

	rgcb_ram #(
		.WIDTH  (COLUMN_BITS),
		.DEPTH  (DISPLAY_COLUMNS),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// output register: free when empty or being taken
	assign res_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_word_q <= res_word;
			out_adv_q  <= res_adv;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_adv_q, out_word_q};

endmodule

`default_nettype wire
